>>> rtl/rgbhsv_pkg.sv
package rgbhsv_pkg;

    // control that travels with an item from stage to stage
    typedef struct packed {
        logic valid;
        logic grey;
    } stage_ctrl_t;

endpackage

>>> rtl/rgbhsv_prep.sv
module rgbhsv_prep #(
    parameter int CB = 8,
    parameter int HB = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CB-1:0]             red,
    input  logic [CB-1:0]             green,
    input  logic [CB-1:0]             blue,
    output rgbhsv_pkg::stage_ctrl_t   ctrl_out,
    input  logic                      ready_in,
    output logic [CB-1:0]             sat_rem,
    output logic [CB-1:0]             sat_low,
    output logic [CB-1:0]             sat_quo,
    output logic [CB-1:0]             hi_val,
    output logic [CB+2:0]             hue_rem,
    output logic [CB+2:0]             six_val,
    output logic [HB-1:0]             hue_quo
);
    import rgbhsv_pkg::*;

    logic              valid_reg;
    logic              grey_reg;
    logic [CB-1:0]     hi;
    logic [CB-1:0]     lo;
    logic [CB-1:0]     delta;
    logic [2*CB-1:0]   prod;
    logic [CB+2:0]     six;
    logic signed [CB+3:0] num;
    logic signed [CB+3:0] num_adj;
    logic [CB-1:0]     sat_rem_reg;
    logic [CB-1:0]     sat_low_reg;
    logic [CB-1:0]     hi_reg;
    logic [CB+2:0]     hue_rem_reg;
    logic [CB+2:0]     six_reg;

    always_comb
    begin
        hi = red;
        if (green > hi)
        begin
            hi = green;
        end
        if (blue > hi)
        begin
            hi = blue;
        end
        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
    end

    assign delta = hi - lo;
    // delta times full scale, as a shift and a subtract
    assign prod  = {delta, {CB{1'b0}}} - {{CB{1'b0}}, delta};
    assign six   = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};

    // sector offset plus signed channel difference, ties go red then green
    always_comb
    begin
        priority if (red == hi)
        begin
            num = $signed({4'b0000, green}) - $signed({4'b0000, blue});
        end
        else if (green == hi)
        begin
            num = $signed({3'b000, delta, 1'b0}) + $signed({4'b0000, blue})
                - $signed({4'b0000, red});
        end
        else
        begin
            num = $signed({2'b00, delta, 2'b00}) + $signed({4'b0000, red})
                - $signed({4'b0000, green});
        end
        if (num < 0)
        begin
            num_adj = num + $signed({1'b0, six});
        end
        else
        begin
            num_adj = num;
        end
    end

    assign in_ready = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            grey_reg  <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
            grey_reg  <= (delta == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sat_rem_reg <= prod[2*CB-1:CB];
            sat_low_reg <= prod[CB-1:0];
            hi_reg      <= hi;
            hue_rem_reg <= num_adj[CB+2:0];
            six_reg     <= six;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.grey  = grey_reg;
    assign sat_rem = sat_rem_reg;
    assign sat_low = sat_low_reg;
    assign sat_quo = '0;
    assign hi_val  = hi_reg;
    assign hue_rem = hue_rem_reg;
    assign six_val = six_reg;
    assign hue_quo = '0;

endmodule

>>> rtl/rgbhsv_div_cell.sv
module rgbhsv_div_cell #(
    parameter int CB       = 8,
    parameter int HB       = 12,
    parameter bit SAT_STEP = 1'b1,
    parameter bit HUE_STEP = 1'b1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rgbhsv_pkg::stage_ctrl_t   ctrl_in,
    output logic                      ready_out,
    input  logic [CB-1:0]             sat_rem_in,
    input  logic [CB-1:0]             sat_low_in,
    input  logic [CB-1:0]             sat_quo_in,
    input  logic [CB-1:0]             hi_in,
    input  logic [CB+2:0]             hue_rem_in,
    input  logic [CB+2:0]             six_in,
    input  logic [HB-1:0]             hue_quo_in,
    output rgbhsv_pkg::stage_ctrl_t   ctrl_out,
    input  logic                      ready_in,
    output logic [CB-1:0]             sat_rem_out,
    output logic [CB-1:0]             sat_low_out,
    output logic [CB-1:0]             sat_quo_out,
    output logic [CB-1:0]             hi_out,
    output logic [CB+2:0]             hue_rem_out,
    output logic [CB+2:0]             six_out,
    output logic [HB-1:0]             hue_quo_out
);
    import rgbhsv_pkg::*;

    logic          valid_reg;
    logic          grey_reg;
    logic [CB:0]   sat_trial;
    logic          sat_bit;
    logic [CB+3:0] hue_trial;
    logic          hue_bit;
    logic [CB-1:0] sat_rem_next;
    logic [CB-1:0] sat_low_next;
    logic [CB-1:0] sat_quo_next;
    logic [CB+2:0] hue_rem_next;
    logic [HB-1:0] hue_quo_next;
    logic [CB-1:0] sat_rem_reg;
    logic [CB-1:0] sat_low_reg;
    logic [CB-1:0] sat_quo_reg;
    logic [CB-1:0] hi_reg;
    logic [CB+2:0] hue_rem_reg;
    logic [CB+2:0] six_reg;
    logic [HB-1:0] hue_quo_reg;

    // one restoring step on each lane whose step parameter is set; a lane with its step off passes through
    assign sat_trial = {sat_rem_in, sat_low_in[CB-1]};
    assign sat_bit   = (sat_trial >= {1'b0, hi_in});
    assign hue_trial = {hue_rem_in, 1'b0};
    assign hue_bit   = (hue_trial >= {1'b0, six_in});

    always_comb
    begin
        if (SAT_STEP)
        begin
            sat_rem_next = sat_bit ? CB'(sat_trial - {1'b0, hi_in}) : sat_trial[CB-1:0];
            sat_low_next = {sat_low_in[CB-2:0], 1'b0};
            sat_quo_next = {sat_quo_in[CB-2:0], sat_bit};
        end
        else
        begin
            sat_rem_next = sat_rem_in;
            sat_low_next = sat_low_in;
            sat_quo_next = sat_quo_in;
        end
        if (HUE_STEP)
        begin
            hue_rem_next = hue_bit ? (CB+3)'(hue_trial - {1'b0, six_in})
                                   : hue_trial[CB+2:0];
            hue_quo_next = {hue_quo_in[HB-2:0], hue_bit};
        end
        else
        begin
            hue_rem_next = hue_rem_in;
            hue_quo_next = hue_quo_in;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            grey_reg  <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= ctrl_in.valid;
            grey_reg  <= ctrl_in.grey;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && ctrl_in.valid)
        begin
            sat_rem_reg <= sat_rem_next;
            sat_low_reg <= sat_low_next;
            sat_quo_reg <= sat_quo_next;
            hi_reg      <= hi_in;
            hue_rem_reg <= hue_rem_next;
            six_reg     <= six_in;
            hue_quo_reg <= hue_quo_next;
        end
    end

    assign ctrl_out.valid = valid_reg;
    assign ctrl_out.grey  = grey_reg;
    assign sat_rem_out = sat_rem_reg;
    assign sat_low_out = sat_low_reg;
    assign sat_quo_out = sat_quo_reg;
    assign hi_out      = hi_reg;
    assign hue_rem_out = hue_rem_reg;
    assign six_out     = six_reg;
    assign hue_quo_out = hue_quo_reg;

endmodule

>>> rtl/rgb_to_hsv_converter_unit.sv
// rgb to hsv pixel converter
// each item passes through the front stage and then through every divide cell in turn
// throughput: one item per cycle while out_stall is low, set by the chain of one-bit divide cells
// each stage holds its item while stalled and empty stages fill behind it
// reset: asynchronous active-low rst_n empties every stage; no item is held after reset
module rgb_to_hsv_converter_unit #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CHANNEL_BITS-1:0]  red,
    input  logic [CHANNEL_BITS-1:0]  green,
    input  logic [CHANNEL_BITS-1:0]  blue,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [HUE_BITS-1:0]      hue,
    output logic [CHANNEL_BITS-1:0]  saturation,
    output logic [CHANNEL_BITS-1:0]  brightness
);
    import rgbhsv_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int HB = HUE_BITS;
    // number of cells: the longer of the two quotients sets the chain length
    localparam int NCELL = (CB > HB) ? CB : HB;

    // link k feeds cell k; link NCELL is the output of the last cell
    stage_ctrl_t   ctrl   [NCELL+1];
    logic          ready  [NCELL+1];
    logic [CB-1:0] s_rem  [NCELL+1];
    logic [CB-1:0] s_low  [NCELL+1];
    logic [CB-1:0] s_quo  [NCELL+1];
    logic [CB-1:0] hi_v   [NCELL+1];
    logic [CB+2:0] h_rem  [NCELL+1];
    logic [CB+2:0] six_v  [NCELL+1];
    logic [HB-1:0] h_quo  [NCELL+1];
    logic          prep_ready;

    // front stage: max, min, delta, hue numerator and the two dividends
    rgbhsv_prep #(
        .CB (CB),
        .HB (HB)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (prep_ready),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .ctrl_out (ctrl[0]),
        .ready_in (ready[0]),
        .sat_rem  (s_rem[0]),
        .sat_low  (s_low[0]),
        .sat_quo  (s_quo[0]),
        .hi_val   (hi_v[0]),
        .hue_rem  (h_rem[0]),
        .six_val  (six_v[0]),
        .hue_quo  (h_quo[0])
    );

    // chain of divide cells, one quotient bit of each lane per cell
    // the saturation lane uses the first CB cells, the hue lane the first HB
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rgbhsv_div_cell #(
            .CB       (CB),
            .HB       (HB),
            .SAT_STEP (k < CB),
            .HUE_STEP (k < HB)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl_in     (ctrl[k]),
            .ready_out   (ready[k]),
            .sat_rem_in  (s_rem[k]),
            .sat_low_in  (s_low[k]),
            .sat_quo_in  (s_quo[k]),
            .hi_in       (hi_v[k]),
            .hue_rem_in  (h_rem[k]),
            .six_in      (six_v[k]),
            .hue_quo_in  (h_quo[k]),
            .ctrl_out    (ctrl[k+1]),
            .ready_in    (ready[k+1]),
            .sat_rem_out (s_rem[k+1]),
            .sat_low_out (s_low[k+1]),
            .sat_quo_out (s_quo[k+1]),
            .hi_out      (hi_v[k+1]),
            .hue_rem_out (h_rem[k+1]),
            .six_out     (six_v[k+1]),
            .hue_quo_out (h_quo[k+1])
        );
    end

    // last cell doubles as the output register
    assign ready[NCELL] = !out_stall;
    assign in_stall     = !prep_ready;
    assign out_valid    = ctrl[NCELL].valid;

    // grey or black pixel: both quotients are forced to zero
    assign hue        = ctrl[NCELL].grey ? '0 : h_quo[NCELL];
    assign saturation = ctrl[NCELL].grey ? '0 : s_quo[NCELL];
    assign brightness = hi_v[NCELL];

    // black pixel gives neither saturation nor hue
    a_black_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (brightness == '0) |-> (saturation == '0) && (hue == '0))
        else $error("black pixel with non-zero saturation or hue");

    // zero saturation only comes from a grey pixel, whose hue is zero
    a_grey_hue : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (saturation == '0) |-> (hue == '0))
        else $error("zero saturation with non-zero hue");

    // an empty output stage never holds back the input
    a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

endmodule
